/* hdl/mcsc_pkg.sv */
// Shared types, widths and codes for the motion and contact state classifier.
package mcsc_pkg;

  // Window geometry and the widths that follow from it. The window length is a
  // power of two, so dividing by it is a right shift by WIN_AW bits.
  localparam int WINDOW_LEN = 32;
  localparam int WIN_AW     = $clog2(WINDOW_LEN);
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
  localparam int MAG_W      = 16;
  localparam int SUM_W      = MAG_W + WIN_AW;
  localparam int ACC_W      = 2 * MAG_W + WIN_AW;
  localparam int CNT_W      = $clog2(WINDOW_LEN + ACC_W + 2);
  localparam int ROOT_STEPS = MAG_W;
  localparam int SQ_AXES    = 3;

  // Configuration port geometry and register reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [31:0] STILL_LIMIT_RST  = 32'd400;
  localparam logic [31:0] MOTION_LIMIT_RST = 32'd2500;
  localparam logic [15:0] CONFIRM_RST      = 16'd2000;
  localparam logic [15:0] RELEASE_RST      = 16'd5000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STILL_LIMIT  = 2'd0,
    CFG_MOTION_LIMIT = 2'd1,
    CFG_CONFIRM_TIME = 2'd2,
    CFG_RELEASE_TIME = 2'd3
  } cfg_reg_t;

  // Reported presence codes.
  typedef enum logic [1:0] {
    PRES_UNKNOWN    = 2'd0,
    PRES_ENGAGED    = 2'd1,
    PRES_DISENGAGED = 2'd2
  } presence_t;

  // Sequencer steps.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_STORE,
    ST_SUM,
    ST_VAR,
    ST_VAR_DIV,
    ST_FLAGS,
    ST_COUNT,
    ST_CLASSIFY,
    ST_OUT
  } seq_state_t;

  // One input request.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               contact;
    logic [15:0]        elapsed_ms;
    logic               sensor_valid;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [1:0]  presence_state;
    logic        still_flag;
    logic [31:0] still_time_ms;
    logic [31:0] accel_variance;
  } out_item_t;

endpackage

/* hdl/motion_contact_state_classifier_core.sv */
// Motion and contact state classifier: window statistics and presence decision.
//
// Requests enter on in_valid/in_stall with an in_item_t payload and leave on
// out_valid/out_stall with an out_item_t payload; each input request yields
// exactly one result request. Configuration registers are written over
// cfg_valid/cfg_ready (always ready); the user must write them only while
// the block is idle, which the block itself does not enforce.
// Work from accept until the result is loaded into the output register:
//   sensor not valid: straight to the output step.
//   window still filling: 3 squares on the shared multiplier, 16 root steps,
//     one write to the window memory.
//   full window: the same, then two passes over the window memory and the
//     flag, count and classify steps.
// One request is worked on at a time: no new request is taken before the
// last is through. in_stall is high from accept until the
// result has entered the output register, so a new request may be accepted
// while a previous result still waits behind out_stall; a stalled result
// simply holds the sequencer in its final step.
// Reset (synchronous, rst_n low) empties the window, clears all counters,
// reports unknown and loads the configuration defaults. No clearing pass.
module motion_contact_state_classifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mcsc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mcsc_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mcsc_pkg::*;

  // Saturating 32-bit add.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Subtract that stops at zero.
  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [15:0] b);
    return (a > {16'd0, b}) ? (a - {16'd0, b}) : 32'd0;
  endfunction

  // Sequencer and datapath registers.
  seq_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  in_item_t               item_r, item_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [31:0]            prod_r, prod_nxt;
  logic                   prod_vld_r, prod_vld_nxt;
  logic [MAG_W:0]         rem_r, rem_nxt;
  logic [MAG_W-1:0]       root_r, root_nxt;
  logic [MAG_W-1:0]       mean_r, mean_nxt;
  logic [MAG_W-1:0]       rdata_r;
  logic                   still_hit_r, still_hit_nxt;
  logic                   motion_r, motion_nxt;

  // Architectural state.
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [WIN_AW-1:0]      ptr_r, ptr_nxt;
  logic [31:0]            variance_r, variance_nxt;
  logic                   still_r, still_nxt;
  logic [31:0]            still_timer_r, still_timer_nxt;
  logic [31:0]            engage_r, engage_nxt;
  logic [31:0]            release_r, release_nxt;
  presence_t              pres_r, pres_nxt;

  // Configuration registers.
  logic [31:0]            still_limit_r, still_limit_nxt;
  logic [31:0]            motion_limit_r, motion_limit_nxt;
  logic [15:0]            confirm_r, confirm_nxt;
  logic [15:0]            release_time_r, release_time_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // Window memory and its port.
  logic [MAG_W-1:0]       win_mem [WINDOW_LEN];
  logic                   mem_we;
  logic [WIN_AW-1:0]      rd_addr;

  // Shared squaring multiplier.
  logic signed [MAG_W:0]     mul_op;
  logic signed [2*MAG_W+1:0] mul_prod;

  // Root step and pass helpers.
  logic [MAG_W+2:0]       rem_sh;
  logic [MAG_W+2:0]       trial;
  logic [ACC_W-1:0]       acc_sum;
  logic [FILL_W-1:0]      fill_inc;
  logic                   cnt_in_win;

  assign mul_prod = mul_op * mul_op;

  // One bit of the digit-by-digit square root per cycle.
  assign rem_sh = {rem_r, acc_r[31:30]};
  assign trial  = {1'b0, root_r, 2'b01};

  assign acc_sum    = acc_r + ACC_W'(rdata_r);
  assign fill_inc   = (fill_r < FILL_W'(WINDOW_LEN)) ? fill_r + 1'b1 : fill_r;
  assign cnt_in_win = (cnt_r < CNT_W'(WINDOW_LEN));

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[ptr_r] <= root_r;
    end
    rdata_r <= win_mem[rd_addr];
  end

  // Configuration writes.
  always_comb begin
    still_limit_nxt  = still_limit_r;
    motion_limit_nxt = motion_limit_r;
    confirm_nxt      = confirm_r;
    release_time_nxt = release_time_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STILL_LIMIT:  still_limit_nxt  = cfg_data;
        CFG_MOTION_LIMIT: motion_limit_nxt = cfg_data;
        CFG_CONFIRM_TIME: confirm_nxt      = cfg_data[15:0];
        CFG_RELEASE_TIME: release_time_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    item_nxt        = item_r;
    acc_nxt         = acc_r;
    prod_nxt        = mul_prod[31:0];
    prod_vld_nxt    = 1'b0;
    rem_nxt         = rem_r;
    root_nxt        = root_r;
    mean_nxt        = mean_r;
    still_hit_nxt   = still_hit_r;
    motion_nxt      = motion_r;
    fill_nxt        = fill_r;
    ptr_nxt         = ptr_r;
    variance_nxt    = variance_r;
    still_nxt       = still_r;
    still_timer_nxt = still_timer_r;
    engage_nxt      = engage_r;
    release_nxt     = release_r;
    pres_nxt        = pres_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    mul_op          = '0;
    mem_we          = 1'b0;
    rd_addr         = cnt_in_win ? cnt_r[WIN_AW-1:0] : '0;

    case (state_r)
      // Take a request; an invalid reading clears the window, variance, stillness, counters and presence at once.
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          if (!in_data.sensor_valid) begin
            still_nxt       = 1'b0;
            still_timer_nxt = '0;
            engage_nxt      = '0;
            release_nxt     = '0;
            fill_nxt        = '0;
            ptr_nxt         = '0;
            variance_nxt    = '0;
            pres_nxt        = PRES_UNKNOWN;
            state_nxt       = ST_OUT;
          end else begin
            state_nxt = ST_SQ;
          end
        end
      end

      // Square the three axes on the shared multiplier and sum them.
      ST_SQ: begin
        if (cnt_r == CNT_W'(0)) begin
          mul_op = $signed({item_r.accel_x[15], item_r.accel_x});
        end else if (cnt_r == CNT_W'(1)) begin
          mul_op = $signed({item_r.accel_y[15], item_r.accel_y});
        end else begin
          mul_op = $signed({item_r.accel_z[15], item_r.accel_z});
        end
        prod_vld_nxt = (cnt_r < CNT_W'(SQ_AXES));
        if (prod_vld_r) begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_AXES)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = ST_ROOT;
        end
      end

      // Integer square root, two radicand bits per step.
      ST_ROOT: begin
        if (rem_sh >= trial) begin
          rem_nxt  = (MAG_W+1)'(rem_sh - trial);
          root_nxt = {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[MAG_W:0];
          root_nxt = {root_r[MAG_W-2:0], 1'b0};
        end
        acc_nxt = acc_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_STORE;
        end
      end

      // Store the magnitude and advance the circular pointer.
      ST_STORE: begin
        mem_we   = 1'b1;
        ptr_nxt  = (ptr_r == WIN_AW'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
        fill_nxt = fill_inc;
        cnt_nxt  = '0;
        acc_nxt  = '0;
        if (fill_inc < FILL_W'(WINDOW_LEN)) begin
          pres_nxt  = PRES_UNKNOWN;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SUM;
        end
      end

      // First pass: sum of the window; the read data is registered, so it follows its address in the next cycle.
      // The mean is the floor of the sum over the window length, a shift.
      ST_SUM: begin
        if (cnt_r != '0) begin
          acc_nxt = acc_sum;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WINDOW_LEN)) begin
          mean_nxt  = acc_sum[SUM_W-1:WIN_AW];
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_VAR;
        end
      end

      // Second pass: squared deviations from the mean, accumulated.
      ST_VAR: begin
        mul_op = $signed({1'b0, rdata_r}) - $signed({1'b0, mean_r});
        prod_vld_nxt = (cnt_r != '0) && (cnt_r <= CNT_W'(WINDOW_LEN));
        if (prod_vld_r) begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WINDOW_LEN + 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_VAR_DIV;
        end
      end

      // Variance: deviation sum shifted down by the window length. The
      // quotient of the window's squared 16-bit deviations always fits in
      // 32 bits, so the slice needs no saturation.
      ST_VAR_DIV: begin
        variance_nxt = acc_r[ACC_W-1:WIN_AW];
        state_nxt    = ST_FLAGS;
      end

      // Compare the variance against both limits.
      ST_FLAGS: begin
        still_hit_nxt = (variance_r < still_limit_r) && !item_r.contact;
        motion_nxt    = (variance_r >= motion_limit_r);
        state_nxt     = ST_COUNT;
      end

      // Stillness timer and evidence counters.
      ST_COUNT: begin
        still_nxt       = still_hit_r;
        still_timer_nxt = still_hit_r ? sat_add(still_timer_r, item_r.elapsed_ms) : '0;
        if (item_r.contact && motion_r) begin
          engage_nxt  = sat_add(engage_r, item_r.elapsed_ms);
          release_nxt = '0;
        end else if (!item_r.contact && still_hit_r) begin
          release_nxt = sat_add(release_r, item_r.elapsed_ms);
          engage_nxt  = '0;
        end else begin
          engage_nxt  = sat_sub(engage_r, item_r.elapsed_ms);
          release_nxt = sat_sub(release_r, item_r.elapsed_ms);
        end
        state_nxt = ST_CLASSIFY;
      end

      // Presence decision with hysteresis.
      ST_CLASSIFY: begin
        if (engage_r >= {16'd0, confirm_r}) begin
          pres_nxt = PRES_ENGAGED;
        end else if (release_r >= {16'd0, release_time_r}) begin
          pres_nxt = PRES_DISENGAGED;
        end else if ((engage_r == '0) && (release_r == '0)) begin
          pres_nxt = PRES_UNKNOWN;
        end
        state_nxt = ST_OUT;
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.presence_state = pres_r;
          out_data_nxt.still_flag     = still_r;
          out_data_nxt.still_time_ms  = still_timer_r;
          out_data_nxt.accel_variance = variance_r;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state, with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      prod_vld_r     <= 1'b0;
      fill_r         <= '0;
      ptr_r          <= '0;
      variance_r     <= '0;
      still_r        <= 1'b0;
      still_timer_r  <= '0;
      engage_r       <= '0;
      release_r      <= '0;
      pres_r         <= PRES_UNKNOWN;
      still_limit_r  <= STILL_LIMIT_RST;
      motion_limit_r <= MOTION_LIMIT_RST;
      confirm_r      <= CONFIRM_RST;
      release_time_r <= RELEASE_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      prod_vld_r     <= prod_vld_nxt;
      fill_r         <= fill_nxt;
      ptr_r          <= ptr_nxt;
      variance_r     <= variance_nxt;
      still_r        <= still_nxt;
      still_timer_r  <= still_timer_nxt;
      engage_r       <= engage_nxt;
      release_r      <= release_nxt;
      pres_r         <= pres_nxt;
      still_limit_r  <= still_limit_nxt;
      motion_limit_r <= motion_limit_nxt;
      confirm_r      <= confirm_nxt;
      release_time_r <= release_time_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    mean_r      <= mean_nxt;
    still_hit_r <= still_hit_nxt;
    motion_r    <= motion_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
